### rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  // default fixed-point setup
  localparam int FRAC_BITS_DEF     = 12;
  localparam int HUE_FRAC_BITS_DEF = 4;

  // input field formats
  localparam int IN_FRAC   = 12;
  localparam int HUE_W     = 16;
  localparam int UNIT_IN_W = 13;
  localparam logic [UNIT_IN_W-1:0] IN_ONE = UNIT_IN_W'(4096);

  // stream word widths
  localparam int CHAN_W      = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // 60 degree hue sectors, red toward magenta
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

### rtl/hsl2rgb_byte.sv
module hsl2rgb_byte
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic signed [FRAC_BITS+3:0] twice,
  output logic        [CHAN_W-1:0]    value
);

  localparam int TW_W = FRAC_BITS + 4;
  localparam int P_W  = TW_W + 8;

  logic [P_W-1:0]           prod;
  logic [P_W-FRAC_BITS-2:0] scaled;

  // times 255 as shift and subtract, then drop FRAC_BITS+1 fraction bits
  always_comb begin
    prod   = {twice, 8'b0} - {8'b0, twice};
    scaled = prod[P_W-1:FRAC_BITS+1];
    if (twice[TW_W-1] || (twice == '0)) begin
      value = '0;
    end else if (|scaled[P_W-FRAC_BITS-2:CHAN_W]) begin
      value = '1;
    end else begin
      value = scaled[CHAN_W-1:0];
    end
  end

endmodule

### rtl/hsl_to_rgb_converter_core.sv
// hsl to rgb pixel converter, nine register stages
// throughput: one word per cycle while the output is taken; each stage holds one word and
//   moves on as soon as the stage after it is free, so bubbles close up under stall
// reset: synchronous active-high rst clears all stage valid bits
module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // s_axis_tdata: hue[15:0], saturation[28:16], lightness[41:29], zero pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // m_axis_tdata: red[7:0], green[15:8], blue[23:16]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int NS = 9;

  // unit values carry FRAC_BITS fraction bits and reach 1.0
  localparam int UNIT_W = FRAC_BITS + 1;
  localparam int UP     = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
  localparam int DN     = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
  localparam logic [UNIT_W:0] ONE = (UNIT_W+1)'(1) << FRAC_BITS;

  // hue geometry
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL   = HUE_SECTOR * 6;
  localparam int OFFSET     = HUE_FULL * ((32768 + HUE_FULL - 1) / HUE_FULL);
  localparam int HU_W       = $clog2(OFFSET + 32768);
  localparam int RH         = (1 << HU_W) / HUE_FULL;
  localparam int RH_W       = $clog2(RH + 1);
  localparam int HM_W       = $clog2(HUE_FULL);
  localparam int HS_W       = $clog2(HUE_SECTOR + 1);
  localparam logic [HU_W:0]   HF_C = (HU_W+1)'(HUE_FULL);
  localparam logic [HM_W-1:0] HS_M = HM_W'(HUE_SECTOR);
  localparam logic [HS_W-1:0] HS_F = HS_W'(HUE_SECTOR);

  // sector width is 15 * 2^(HUE_FRAC_BITS+2): shift, then divide by 15
  localparam int SEC_ODD = 15;
  localparam int V_W     = UNIT_W + HS_W - HUE_FRAC_BITS - 2;
  localparam int RX      = (1 << V_W) / SEC_ODD;
  localparam int RX_W    = $clog2(RX + 1);
  localparam logic [V_W-1:0] SEC_ODD_V = V_W'(SEC_ODD);

  localparam int TW_W = FRAC_BITS + 4;

  // stage valid bits and ready chain
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic [NS-1:0] vin;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vin = {vld[NS-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NS-1];

  // ---------------------------------------------------------------- stage 1
  // clamp and rescale s and l, offset hue to a non-negative value, 1-|2l-1|
  logic [HUE_W-1:0]           hue_in;
  logic [UNIT_IN_W-1:0]       sat_cl, lit_cl;
  logic [UNIT_IN_W+FRAC_BITS-1:0] sat_w, lit_w;
  logic [UNIT_W-1:0]          sat_u, lit_u;
  logic [UNIT_W:0]            lit_2x, lit_dev;
  logic [HU_W-1:0]            hu_in;

  always_comb begin
    hue_in = s_axis_tdata[HUE_W-1:0];
    sat_cl = s_axis_tdata[HUE_W+UNIT_IN_W-1:HUE_W];
    lit_cl = s_axis_tdata[HUE_W+2*UNIT_IN_W-1:HUE_W+UNIT_IN_W];
    if (sat_cl > IN_ONE) begin
      sat_cl = IN_ONE;
    end
    if (lit_cl > IN_ONE) begin
      lit_cl = IN_ONE;
    end
    sat_w  = ({{FRAC_BITS{1'b0}}, sat_cl} << UP) >> DN;
    lit_w  = ({{FRAC_BITS{1'b0}}, lit_cl} << UP) >> DN;
    sat_u  = sat_w[UNIT_W-1:0];
    lit_u  = lit_w[UNIT_W-1:0];
    lit_2x = {lit_u, 1'b0};
    if (lit_2x >= ONE) begin
      lit_dev = lit_2x - ONE;
    end else begin
      lit_dev = ONE - lit_2x;
    end
    hu_in = {{(HU_W-HUE_W){hue_in[HUE_W-1]}}, hue_in} + HU_W'(OFFSET);
  end

  logic [HU_W-1:0]   hu1;
  logic [UNIT_W-1:0] sat1, lit1, om1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hu1  <= hu_in;
      sat1 <= sat_u;
      lit1 <= lit_u;
      om1  <= UNIT_W'(ONE - lit_dev);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // hue quotient estimate by reciprocal, chroma product
  logic [HU_W+RH_W-1:0] qh_prod;
  assign qh_prod = hu1 * RH_W'(RH);

  logic [RH_W-1:0]     qh2;
  logic [HU_W-1:0]     hu2;
  logic [2*UNIT_W-1:0] cp2;
  logic [UNIT_W-1:0]   lit2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      qh2  <= qh_prod[HU_W+RH_W-1:HU_W];
      hu2  <= hu1;
      cp2  <= om1 * sat1;
      lit2 <= lit1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // hue remainder, estimate may be one low so correct once
  logic [HU_W:0] hdiff, hfix;

  always_comb begin
    hdiff = {1'b0, hu2} - (HU_W+1)'(qh2) * HF_C;
    hfix  = (hdiff >= HF_C) ? hdiff - HF_C : hdiff;
  end

  logic [HM_W-1:0]   hm3;
  logic [UNIT_W-1:0] c3, lit3;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      hm3  <= hfix[HM_W-1:0];
      c3   <= cp2[FRAC_BITS+UNIT_W-1:FRAC_BITS];
      lit3 <= lit2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // sector and distance into it, mirrored in odd sectors
  logic [2:0]      sec_cnt;
  logic [HM_W-1:0] hrem;
  logic [HS_W-1:0] fdist;

  always_comb begin
    sec_cnt = '0;
    for (int k = 1; k < 6; k++) begin
      if (hm3 >= HM_W'(k * HUE_SECTOR)) begin
        sec_cnt = sec_cnt + 3'd1;
      end
    end
    hrem  = hm3 - HM_W'(sec_cnt) * HS_M;
    fdist = sec_cnt[0] ? HS_F - HS_W'(hrem) : HS_W'(hrem);
  end

  sector_t           sec4;
  logic [HS_W-1:0]   f4;
  logic [UNIT_W-1:0] c4, lit4;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sec4 <= sector_t'(sec_cnt);
      f4   <= fdist;
      c4   <= c3;
      lit4 <= lit3;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // minor component numerator
  logic [UNIT_W+HS_W-1:0] xp5;
  sector_t                sec5;
  logic [UNIT_W-1:0]      c5, lit5;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      xp5  <= c4 * f4;
      sec5 <= sec4;
      c5   <= c4;
      lit5 <= lit4;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // drop the power-of-two part of the sector width, reciprocal of 15
  logic [V_W-1:0] xv;
  assign xv = xp5[UNIT_W+HS_W-1:HUE_FRAC_BITS+2];

  logic [V_W+RX_W-1:0] qx6;
  logic [V_W-1:0]      v6;
  sector_t             sec6;
  logic [UNIT_W-1:0]   c6, lit6;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      qx6  <= xv * RX_W'(RX);
      v6   <= xv;
      sec6 <= sec5;
      c6   <= c5;
      lit6 <= lit5;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // quotient may be one low, fix with the remainder
  logic [RX_W-1:0] qx;
  logic [V_W-1:0]  xrem;

  always_comb begin
    qx   = qx6[V_W+RX_W-1:V_W];
    xrem = v6 - V_W'(qx) * SEC_ODD_V;
  end

  logic [UNIT_W-1:0] x7, c7, lit7;
  sector_t           sec7;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      x7   <= UNIT_W'(qx) + UNIT_W'(xrem >= SEC_ODD_V);
      sec7 <= sec6;
      c7   <= c6;
      lit7 <= lit6;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // route chroma and minor component, add offset at twice the scale
  logic [UNIT_W-1:0] rp, gp, bp;

  function automatic logic signed [TW_W-1:0] chan_twice(
    input logic [UNIT_W-1:0] comp,
    input logic [UNIT_W-1:0] lit,
    input logic [UNIT_W-1:0] chroma
  );
    logic signed [TW_W-1:0] tw;
    tw = $signed({2'b0, comp, 1'b0}) + $signed({2'b0, lit, 1'b0})
       - $signed({3'b0, chroma});
    return tw;
  endfunction

  always_comb begin
    rp = '0;
    gp = '0;
    bp = '0;
    unique case (sec7)
      SEC_RY: begin
        rp = c7;
        gp = x7;
      end
      SEC_YG: begin
        rp = x7;
        gp = c7;
      end
      SEC_GC: begin
        gp = c7;
        bp = x7;
      end
      SEC_CB: begin
        gp = x7;
        bp = c7;
      end
      SEC_BM: begin
        bp = c7;
        rp = x7;
      end
      default: begin
        bp = x7;
        rp = c7;
      end
    endcase
  end

  logic signed [TW_W-1:0] tr8, tg8, tb8;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      tr8 <= chan_twice(rp, lit7, c7);
      tg8 <= chan_twice(gp, lit7, c7);
      tb8 <= chan_twice(bp, lit7, c7);
    end
  end

  // ---------------------------------------------------------------- stage 9
  // scale to 8 bits and clamp, output register
  logic [CHAN_W-1:0] red_b, green_b, blue_b;

  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_r (.twice(tr8), .value(red_b));
  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_g (.twice(tg8), .value(green_b));
  hsl2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte_b (.twice(tb8), .value(blue_b));

  logic [CHAN_W-1:0] red9, green9, blue9;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      red9   <= red_b;
      green9 <= green_b;
      blue9  <= blue_b;
    end
  end

  assign m_axis_tdata = {blue9, green9, red9};

  // ---------------------------------------------------------------- checks
  // an empty output stage means the whole pipe can move
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready
  ) else $error("input not ready with empty output stage");

  // input backpressure only comes from a stalled output word
  a_stall_source: assert property (
    @(posedge clk) disable iff (rst)
      !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
  ) else $error("input stalled without output backpressure");

  // an accepted word lands in the first stage
  a_accept_lands: assert property (
    @(posedge clk) disable iff (rst)
      (s_axis_tvalid && s_axis_tready) |=> vld[0]
  ) else $error("accepted word lost at first stage");

  // a stalled output word is not dropped
  a_out_held: assert property (
    @(posedge clk) disable iff (rst)
      (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata))
  ) else $error("stalled output word changed");

endmodule

### tb/tb_hsl_to_rgb_converter_core.sv
module tb_hsl_to_rgb_converter_core;
  import hsl2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point geometry of the default build
  localparam int HUE_SECTOR     = 60 << HUE_FRAC_BITS_DEF;
  localparam int HUE_FULL       = 6 * HUE_SECTOR;
  localparam int UNIT_ONE       = 1 << FRAC_BITS_DEF;
  localparam int PIPE_LATENCY   = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PAD_W          = IN_TDATA_W - HUE_W - 2 * UNIT_IN_W;

  // receiver stall patterns
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} sink_mode_t;

  // red in the lowest bits, as on the result bus
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // hue[15:0], saturation[28:16], lightness[41:29], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // red[7:0], green[15:8], blue[23:16]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  rgb_t       rgb_pending[$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  sink_mode_t rx_mode = RX_ALWAYS;
  int         hold_ticket = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  logic [10:0] rx_pattern = 11'b10110011101;
  rgb_t       want;
  rgb_t       got;

  hsl_to_rgb_converter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // channel carries FRAC_BITS+1 fraction bits; scale to 255, truncate, clamp
  function automatic logic [CHAN_W-1:0] channel_byte(input longint twice);
    longint v;
    if (twice <= 0) return '0;
    v = (twice * 255) >>> (FRAC_BITS_DEF + 1);
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic rgb_t hsl_pixel_to_rgb(input logic [HUE_W-1:0] hue,
                                            input logic [UNIT_IN_W-1:0] sat,
                                            input logic [UNIT_IN_W-1:0] light);
    longint  s, l, lit_dev, c, x, base, rp, gp, bp;
    int      h, hm, rem, f;
    sector_t sec;
    rgb_t    px;
    h  = int'($signed(hue));
    // values above one saturate to one
    s  = (sat > IN_ONE) ? longint'(IN_ONE) : longint'(sat);
    l  = (light > IN_ONE) ? longint'(IN_ONE) : longint'(light);
    // true modulo so negative hue wraps to the top of the circle
    hm = h % HUE_FULL;
    if (hm < 0) hm += HUE_FULL;
    sec = sector_t'(hm / HUE_SECTOR);
    rem = hm % HUE_SECTOR;
    // odd sectors ramp down, even sectors ramp up
    f  = sec[0] ? (HUE_SECTOR - rem) : rem;
    lit_dev = 2 * l - UNIT_ONE;
    if (lit_dev < 0) lit_dev = -lit_dev;
    c  = ((UNIT_ONE - lit_dev) * s) >>> FRAC_BITS_DEF;
    x  = (c * f) / HUE_SECTOR;
    rp = 0;
    gp = 0;
    bp = 0;
    case (sec)
      SEC_RY: begin rp = c; gp = x; end
      SEC_YG: begin rp = x; gp = c; end
      SEC_GC: begin gp = c; bp = x; end
      SEC_CB: begin gp = x; bp = c; end
      SEC_BM: begin bp = c; rp = x; end
      default: begin bp = x; rp = c; end
    endcase
    base = 2 * l - c;
    px.red   = channel_byte(2 * rp + base);
    px.green = channel_byte(2 * gp + base);
    px.blue  = channel_byte(2 * bp + base);
    return px;
  endfunction

  // biased toward sector edges and the wrap points
  function automatic logic [HUE_W-1:0] random_hue();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, 5)) * HUE_SECTOR + int'($urandom_range(0, 2)) - 1
                + (int'($urandom_range(0, 8)) - 4) * HUE_FULL;
      2, 3, 4: v = int'($urandom_range(0, HUE_FULL - 1));
      default: v = int'($urandom);
    endcase
    return HUE_W'(v);
  endfunction

  // mostly in range, with the ends, mid-grey and above-one values mixed in
  function automatic logic [UNIT_IN_W-1:0] random_unit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IN_ONE;
      2: return UNIT_IN_W'($urandom_range(4097, 8191));
      3: return UNIT_IN_W'($urandom_range(2040, 2056));
      default: return UNIT_IN_W'($urandom_range(0, 4096));
    endcase
  endfunction

  // offer one word and hold it until the core takes it; valid stays high after
  task automatic send_pixel(input logic [HUE_W-1:0] hue,
                            input logic [UNIT_IN_W-1:0] sat,
                            input logic [UNIT_IN_W-1:0] light);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, light, sat, hue};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rgb_pending.push_back(hsl_pixel_to_rgb(hue, sat, light));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering and let the pipeline run dry
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // primaries, secondaries, wrap points, grey and the saturating ends
  task automatic test_corners();
    rx_mode <= RX_ALWAYS;
    send_pixel(16'sd0,     13'd4096, 13'd2048);
    send_pixel(16'sd960,   13'd4096, 13'd2048);
    send_pixel(16'sd1920,  13'd4096, 13'd2048);
    send_pixel(16'sd2880,  13'd4096, 13'd2048);
    send_pixel(16'sd3840,  13'd4096, 13'd2048);
    send_pixel(16'sd4800,  13'd4096, 13'd2048);
    send_pixel(16'sd480,   13'd4096, 13'd2048);
    send_pixel(16'sd1440,  13'd4096, 13'd2048);
    send_pixel(16'sd959,   13'd4096, 13'd2048);
    send_pixel(16'sd961,   13'd4096, 13'd2048);
    send_pixel(16'sd5759,  13'd4096, 13'd2048);
    send_pixel(16'sd5760,  13'd4096, 13'd2048);
    send_pixel(-16'sd1,    13'd4096, 13'd2048);
    send_pixel(16'h8000,   13'd4096, 13'd2048);
    send_pixel(16'h7fff,   13'd4096, 13'd2048);
    send_pixel(16'sd2000,  13'd0,    13'd3000);
    send_pixel(16'sd2000,  13'd4096, 13'd0);
    send_pixel(16'sd2000,  13'd4096, 13'd4096);
    send_pixel(16'sd2000,  13'd8191, 13'd2048);
    send_pixel(16'sd2000,  13'd4096, 13'd8191);
    send_pixel(16'sd4000,  13'd4097, 13'd4097);
    send_pixel(16'sd300,   13'd4096, 13'd2047);
    send_pixel(16'sd300,   13'd4096, 13'd2049);
    send_pixel(16'sd5000,  13'd1,    13'd1);
    send_pixel(16'hffff,   13'd1234, 13'd8191);
    wait_results();
  endtask

  // sink holds off for a long stretch while words keep coming, so the
  // pipeline fills and tready drops
  task automatic test_backpressure();
    rx_mode <= RX_ALWAYS;
    hold_ticket = hold_ticket + 1;
    repeat (40) send_pixel(random_hue(), random_unit(), random_unit());
    wait_results();
  endtask

  task automatic test_random(input int n);
    int burst_left;
    int i;
    bit gapless;
    burst_left = 0;
    for (i = 0; i < n; i++) begin
      // every 150 words the sink changes its stall habit
      if (i % 150 == 0) rx_mode <= sink_mode_t'($urandom_range(0, 3));
      // first 40 words of each 200 go back to back
      gapless = (i % 200) < 40;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!gapless) idle_gap($urandom_range(1, 6));
      end
      burst_left--;
      send_pixel(random_hue(), random_unit(), random_unit());
    end
    wait_results();
  endtask

  // sink ready generation; a new hold ticket starts a long hold-off
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    rx_pattern <= {rx_pattern[0], rx_pattern[10:1]};
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 9) < 7);
        RX_PATTERN: m_axis_tready <= rx_pattern[0];
        default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result checker: oldest expectation against each accepted result word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rgb_pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = rgb_pending.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
          mismatch_count++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
          mismatch_count++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_hsl_to_rgb_converter_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_backpressure();
    test_random(800);
    if (mismatch_count == 0 && rgb_pending.size() == 0) begin
      $display("tb_hsl_to_rgb_converter_core OK");
    end else begin
      $display("tb_hsl_to_rgb_converter_core NOT OK");
    end
    $finish;
  end

endmodule
